// ===== hdl/tmps_pkg.sv =====
`default_nettype none
package tmps_pkg;

    // default table resolution for the log2 and exp2 tables
    localparam int DEF_LOG_TABLE_BITS = 8;

    // widths of the fixed-point paths
    localparam int OFFW = 9;   // exponent offset into a log unit
    localparam int LGW  = 28;  // log2 values, signed q.16
    localparam int LSW  = 40;  // log2 of the pixel scale, signed q.16
    localparam int SUMW = 43;  // signed luminance sum
    localparam int LUMW = 41;  // positive luminance magnitude
    localparam int BEW  = 26;  // biased result exponent

    localparam logic [16:0] LOG2_PI_Q16  = 17'd108233;
    localparam int          LUM_EXP_OFF  = 166;
    localparam int          EFF_EXP_OFF  = 150;
    localparam int          PROD_EXP_OFF = 46;

    // rec.709 luminance weights, q0.16
    localparam logic [15:0] LUM_W [3] = '{16'd13933, 16'd46871, 16'd4732};

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DISPLAY_MODE = 3'd0,
        REG_EXPONENT_G   = 3'd1,
        REG_GAIN_COMPUTE = 3'd2,
        REG_GAIN_DISPLAY = 3'd3,
        REG_ADAPT_LUM    = 3'd4,
        REG_EFFICACY     = 3'd5
    } cfg_idx_t;

    // one unpacked fp32 channel
    typedef struct packed {
        logic        neg;
        logic [7:0]  ex;
        logic [23:0] mant;
    } chan_t;

    // per-pixel control carried to the channel scalers
    typedef struct packed {
        logic kill;
        logic flip;
    } side_t;

    // inf and nan count as zero, denormals keep their exact value
    function automatic chan_t unpack_fp32(input logic [31:0] bits);
        chan_t c;
        c.neg = bits[31];
        if (bits[30:23] == 8'hFF) begin
            c.mant = '0;
            c.ex   = 8'd1;
        end else if (bits[30:23] == 8'h00) begin
            c.mant = {1'b0, bits[22:0]};
            c.ex   = 8'd1;
        end else begin
            c.mant = {1'b1, bits[22:0]};
            c.ex   = bits[30:23];
        end
        return c;
    endfunction

    // log2 of m / 2^23 in q0.16 by repeated squaring, truncated
    function automatic logic [15:0] frac_log2(input logic [23:0] m);
        logic [63:0] x;
        logic [15:0] r;
        x = {33'd0, m, 7'd0};
        r = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                x    = x >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // log2 table entry, q0.16
    function automatic logic [16:0] lg_entry(input int i, input int ltb);
        logic [23:0] m;
        m = 24'h800000 | 24'(i << (23 - ltb));
        if (i >= (1 << ltb)) begin
            return 17'h10000;
        end
        return {1'b0, frac_log2(m)};
    endfunction

    // exp2 table entry: smallest q1.23 mantissa whose log reaches the target
    function automatic logic [24:0] ex_entry(input int i, input int ltb);
        logic [24:0] lo;
        logic [24:0] hi;
        logic [24:0] mid;
        logic [16:0] target;
        target = 17'(i << (16 - ltb));
        lo     = 25'h0800000;
        hi     = 25'h1000000;
        mid    = lo;
        if (i >= (1 << ltb)) begin
            return 25'h1000000;
        end
        for (int k = 0; k < 26; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if ({1'b0, frac_log2(mid[23:0])} >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 25'd1;
                end
            end
        end
        return lo;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tone_map_pixel_scaler.sv =====
`default_nettype none
// Tone-mapping pixel scaler: takes one fp32 RGB radiance pixel per word and returns the
// tone-mapped fp32 pixel, scaled by gain * (L/La)^g / L with L the Rec.709 luminance,
// all worked in a log2 domain from small interpolated tables (2^LOG_TABLE_BITS + 1
// entries each). It accepts one pixel every clock unless the output stalls, through the
// fixed 14-stage pipeline (luminance, log2 unit, tone curve multiply, exp2 unit, channel
// multiply and normalise); a stall on the output holds the whole pipeline. The user must
// write registers through the cfg port only while no pixel is in flight; the block does
// not enforce it. Non-positive luminance, or zero efficacy in display mode, zeroes the pixel.
module tone_map_pixel_scaler
    import tmps_pkg::*;
#(
    parameter int LOG_TABLE_BITS = DEF_LOG_TABLE_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // red_in, green_in, blue_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata    // red_out, green_out, blue_out
);

    localparam int NST    = 14;
    localparam int ST_CH  = 11;
    localparam int MULW   = 17 + LGW;

    // configuration registers
    logic                  dm_reg;
    logic [15:0]           g_reg;
    logic signed [23:0]    gc_reg, gd_reg, la_reg;
    logic [31:0]           eff_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dm_reg      <= 1'b0;
            g_reg       <= 16'd4096;
            gc_reg      <= '0;
            gd_reg      <= '0;
            la_reg      <= '0;
            eff_cfg_reg <= 32'h442AC000;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_DISPLAY_MODE: dm_reg      <= cfg_wr_data[0];
                REG_EXPONENT_G:   g_reg       <= cfg_wr_data[15:0];
                REG_GAIN_COMPUTE: gc_reg      <= cfg_wr_data[23:0];
                REG_GAIN_DISPLAY: gd_reg      <= cfg_wr_data[23:0];
                REG_ADAPT_LUM:    la_reg      <= cfg_wr_data[23:0];
                REG_EFFICACY:     eff_cfg_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic             en;
    logic [NST:1]     vld_reg;

    assign en       = !vld_reg[NST] || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = vld_reg[NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-1:1], s_tvalid};
        end
    end

    // stage 1: unpack and largest exponent
    chan_t       pix_in [3];
    chan_t       pix_dly_reg [1:ST_CH][3];
    logic [7:0]  emax_next, t1_emax_reg, t2_emax_reg;
    logic        any_next, t1_any_reg, t2_any_reg;
    chan_t       t1_eff_reg, t2_eff_reg;

    always_comb begin
        emax_next = '0;
        any_next  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pix_in[i] = unpack_fp32(s_tdata[32*i +: 32]);
            if (pix_in[i].mant != '0 && (!any_next || pix_in[i].ex > emax_next)) begin
                emax_next = pix_in[i].ex;
                any_next  = 1'b1;
            end
        end
    end

    // stage 2: weighted mantissas
    logic [39:0] pw_next [3];
    logic [39:0] t2_pw_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pw_next[i] = {16'd0, pix_dly_reg[1][i].mant} * {24'd0, LUM_W[i]};
        end
    end

    // stage 3: aligned signed luminance sum
    logic signed [SUMW-1:0] sum_next, term_c;
    logic [7:0]             d_c;
    side_t                  side_next;
    side_t                  side_dly_reg [3:ST_CH];
    logic [LUMW-1:0]        lum_v_reg;
    logic signed [OFFW-1:0] lum_off_reg, eff_off_reg;
    logic [23:0]            eff_v_reg;

    always_comb begin
        sum_next = '0;
        term_c   = '0;
        d_c      = '0;
        for (int i = 0; i < 3; i++) begin
            d_c    = t2_emax_reg - pix_dly_reg[2][i].ex;
            term_c = SUMW'(t2_pw_reg[i] >> d_c);
            if (pix_dly_reg[2][i].neg) begin
                sum_next = sum_next - term_c;
            end else begin
                sum_next = sum_next + term_c;
            end
        end
        side_next.kill = !t2_any_reg || sum_next[SUMW-1] || (sum_next == '0)
                       || (dm_reg && t2_eff_reg.mant == '0);
        side_next.flip = dm_reg && t2_eff_reg.neg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_dly_reg[1] <= pix_in;
            for (int k = 2; k <= ST_CH; k++) begin
                pix_dly_reg[k] <= pix_dly_reg[k-1];
            end
            t1_emax_reg <= emax_next;
            t1_any_reg  <= any_next;
            t1_eff_reg  <= unpack_fp32(eff_cfg_reg);
            t2_emax_reg <= t1_emax_reg;
            t2_any_reg  <= t1_any_reg;
            t2_eff_reg  <= t1_eff_reg;
            t2_pw_reg   <= pw_next;
            lum_v_reg   <= sum_next[LUMW-1:0];
            lum_off_reg <= signed'({1'b0, t2_emax_reg}) - OFFW'(LUM_EXP_OFF);
            eff_v_reg   <= t2_eff_reg.mant;
            eff_off_reg <= signed'({1'b0, t2_eff_reg.ex}) - OFFW'(EFF_EXP_OFF);
            side_dly_reg[3] <= side_next;
            for (int k = 4; k <= ST_CH; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // stages 4 to 6: log2 of luminance and of efficacy
    logic signed [LGW-1:0] lum_lg, eff_lg;

    tmps_log2 #(.VW(LUMW), .LTB(LOG_TABLE_BITS)) u_log_lum (
        .aclk (aclk),
        .en   (en),
        .v    (lum_v_reg),
        .off  (lum_off_reg),
        .lg   (lum_lg)
    );

    tmps_log2 #(.VW(24), .LTB(LOG_TABLE_BITS)) u_log_eff (
        .aclk (aclk),
        .en   (en),
        .v    (eff_v_reg),
        .off  (eff_off_reg),
        .lg   (eff_lg)
    );

    // stages 7 to 9: tone curve in the log domain
    logic signed [LGW-1:0]  lgl_next, dif_next, efft_next;
    logic signed [LGW-1:0]  t7_lgl_reg, t7_dif_reg, t7_efft_reg;
    logic signed [LGW-1:0]  t8_lgl_reg, t8_efft_reg;
    logic signed [MULW-1:0] mul_next, t8_mul_reg;
    logic signed [23:0]     gain_c;
    logic signed [LSW-1:0]  ls_next, t9_ls_reg;

    always_comb begin
        lgl_next  = lum_lg + (dm_reg ? LGW'(signed'({1'b0, LOG2_PI_Q16})) : '0);
        dif_next  = lgl_next - LGW'(la_reg);
        efft_next = dm_reg ? eff_lg + LGW'(signed'({1'b0, LOG2_PI_Q16})) : '0;
        mul_next  = signed'({1'b0, g_reg}) * t7_dif_reg;
        gain_c    = dm_reg ? gd_reg : gc_reg;
        ls_next   = LSW'(gain_c) + LSW'(t8_mul_reg >>> 12) - LSW'(t8_lgl_reg)
                  + LSW'(t8_efft_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t7_lgl_reg  <= lgl_next;
            t7_dif_reg  <= dif_next;
            t7_efft_reg <= efft_next;
            t8_mul_reg  <= mul_next;
            t8_lgl_reg  <= t7_lgl_reg;
            t8_efft_reg <= t7_efft_reg;
            t9_ls_reg   <= ls_next;
        end
    end

    // stages 10 and 11: scale mantissa and power of two
    logic signed [LSW-17:0] sc_ip;
    logic [24:0]            sc_fm;

    tmps_exp2 #(.LTB(LOG_TABLE_BITS)) u_exp (
        .aclk (aclk),
        .en   (en),
        .ls   (t9_ls_reg),
        .ip   (sc_ip),
        .fm   (sc_fm)
    );

    // stages 12 to 14: per-channel scaling
    for (genvar i = 0; i < 3; i++) begin : g_chan
        tmps_chan u_chan (
            .aclk (aclk),
            .en   (en),
            .chan (pix_dly_reg[ST_CH][i]),
            .ctl  (side_dly_reg[ST_CH]),
            .fm   (sc_fm),
            .ip   (sc_ip),
            .res  (m_tdata[32*i +: 32])
        );
    end

`ifndef SYNTHESIS
    // results are finite: saturation never reaches the inf exponent
    a_no_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:23] != 8'hFF) && (m_tdata[62:55] != 8'hFF)
                     && (m_tdata[94:87] != 8'hFF))
        else $error("tone map result with inf or nan exponent");

    // underflow flushes: no denormal or negative zero leaves the block
    a_no_denorm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:23] != 8'h00 || m_tdata[31:0] == 32'd0)
                     && (m_tdata[62:55] != 8'h00 || m_tdata[63:32] == 32'd0)
                     && (m_tdata[94:87] != 8'h00 || m_tdata[95:64] == 32'd0))
        else $error("tone map result denormal or signed zero");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");
`endif

endmodule
`default_nettype wire

// ===== hdl/tmps_log2.sv =====
`default_nettype none
module tmps_log2
    import tmps_pkg::*;
#(
    parameter int VW  = LUMW,
    parameter int LTB = DEF_LOG_TABLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [VW-1:0]          v,
    input  wire logic signed [OFFW-1:0] off,
    output logic signed [LGW-1:0]       lg
);

    localparam int N   = 1 << LTB;
    localparam int SH  = 23 - LTB;
    localparam int PW  = $clog2(VW);
    localparam int IPW = OFFW + 1;

    typedef logic [16:0] lg_tab_t [0:N];

    function automatic lg_tab_t build_lg_tab();
        lg_tab_t t;
        for (int i = 0; i <= N; i++) begin
            t[i] = lg_entry(i, LTB);
        end
        return t;
    endfunction

    localparam lg_tab_t LG_TAB = build_lg_tab();

    logic [VW-1:0]          v_reg;
    logic signed [OFFW-1:0] off_reg;
    logic [PW-1:0]          p_reg, p_next;
    logic [16:0]            a_reg, a_next, b_reg, b_next;
    logic [SH-1:0]          rem_reg, rem_next;
    logic signed [IPW-1:0]  ipart_reg, ipart_next;
    logic signed [LGW-1:0]  lg_reg, lg_next;

    logic [VW+22:0]         wide_sh;
    logic [LTB-1:0]         idx;
    logic [16+SH:0]         interp_prod;
    logic [17:0]            lm;

    // leading one position
    always_comb begin
        p_next = '0;
        for (int k = 0; k < VW; k++) begin
            if (v[k]) begin
                p_next = PW'(k);
            end
        end
    end

    // normalise to 1.23 and read the two table neighbours
    always_comb begin
        wide_sh    = {v_reg, 23'd0} >> p_reg;
        idx        = wide_sh[22 -: LTB];
        rem_next   = wide_sh[SH-1:0];
        a_next     = LG_TAB[{1'b0, idx}];
        b_next     = LG_TAB[{1'b0, idx} + 1'b1];
        ipart_next = IPW'(signed'({1'b0, p_reg})) + IPW'(off_reg);
    end

    // linear interpolation plus integer part
    always_comb begin
        interp_prod = (b_reg - a_reg) * rem_reg;
        lm          = {1'b0, a_reg} + {1'b0, interp_prod[16+SH:SH]};
        lg_next     = LGW'(signed'({ipart_reg, 16'd0})) + LGW'(signed'({1'b0, lm}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg     <= v;
            off_reg   <= off;
            p_reg     <= p_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            rem_reg   <= rem_next;
            ipart_reg <= ipart_next;
            lg_reg    <= lg_next;
        end
    end

    assign lg = lg_reg;

endmodule
`default_nettype wire

// ===== hdl/tmps_exp2.sv =====
`default_nettype none
module tmps_exp2
    import tmps_pkg::*;
#(
    parameter int LTB = DEF_LOG_TABLE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [LSW-1:0] ls,
    output logic signed [LSW-17:0]     ip,
    output logic [24:0]                fm
);

    localparam int N   = 1 << LTB;
    localparam int ESH = 16 - LTB;

    typedef logic [24:0] ex_tab_t [0:N];

    function automatic ex_tab_t build_ex_tab();
        ex_tab_t t;
        for (int i = 0; i <= N; i++) begin
            t[i] = ex_entry(i, LTB);
        end
        return t;
    endfunction

    localparam ex_tab_t EX_TAB = build_ex_tab();

    logic [24:0]            a_reg, a_next, b_reg, b_next;
    logic [ESH-1:0]         rem_reg, rem_next;
    logic signed [LSW-17:0] ip1_reg, ip2_reg;
    logic [24:0]            fm_reg, fm_next;
    logic [LTB-1:0]         idx;
    logic [24+ESH:0]        interp_prod;

    // split into integer part and table index of the fraction
    always_comb begin
        idx      = ls[15 -: LTB];
        rem_next = ls[ESH-1:0];
        a_next   = EX_TAB[{1'b0, idx}];
        b_next   = EX_TAB[{1'b0, idx} + 1'b1];
    end

    // interpolated mantissa, q1.23
    always_comb begin
        interp_prod = (b_reg - a_reg) * rem_reg;
        fm_next     = a_reg + interp_prod[24+ESH:ESH];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            rem_reg <= rem_next;
            ip1_reg <= ls[LSW-1:16];
            ip2_reg <= ip1_reg;
            fm_reg  <= fm_next;
        end
    end

    assign ip = ip2_reg;
    assign fm = fm_reg;

endmodule
`default_nettype wire

// ===== hdl/tmps_chan.sv =====
`default_nettype none
module tmps_chan
    import tmps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire chan_t                 chan,
    input  wire side_t                 ctl,
    input  wire logic [24:0]           fm,
    input  wire logic signed [LSW-17:0] ip,
    output logic [31:0]                res
);

    logic [48:0]           prod_reg, prod_next, prod2_reg, shifted;
    logic signed [BEW-1:0] exb_reg, exb_next, exb2_reg, be;
    logic                  sign_reg, sign_next, sign2_reg;
    logic                  zero_reg, zero_next, zero2_reg;
    logic [5:0]            q_reg, q_next;
    logic [31:0]           res_reg, res_next;

    // mantissa product and exponent bias
    always_comb begin
        prod_next = {25'd0, chan.mant} * {24'd0, fm};
        exb_next  = BEW'(signed'({1'b0, chan.ex})) + BEW'(ip) - BEW'(PROD_EXP_OFF);
        sign_next = chan.neg ^ ctl.flip;
        zero_next = ctl.kill || (chan.mant == '0);
    end

    // leading one of the product
    always_comb begin
        q_next = '0;
        for (int k = 0; k < 49; k++) begin
            if (prod_reg[k]) begin
                q_next = 6'(k);
            end
        end
    end

    // normalise, saturate or flush, pack
    always_comb begin
        shifted = prod2_reg << (6'd48 - q_reg);
        be      = exb2_reg + BEW'(signed'({1'b0, q_reg}));
        if (zero2_reg || be <= 0) begin
            res_next = '0;
        end else if (be >= 255) begin
            res_next = {sign2_reg, 31'h7F7FFFFF};
        end else begin
            res_next = {sign2_reg, be[7:0], shifted[47:25]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            exb_reg   <= exb_next;
            sign_reg  <= sign_next;
            zero_reg  <= zero_next;
            q_reg     <= q_next;
            prod2_reg <= prod_reg;
            exb2_reg  <= exb_reg;
            sign2_reg <= sign_reg;
            zero2_reg <= zero_reg;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire
